// ===== src/sec_pkg.sv =====
// Shared types and constants for the SECDED (72,64) check-and-correct block.
// Holds the check-bit mask rows, the syndrome decode table and the outcome codes.
// No dependencies.
package sec_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CheckW = 8;
  localparam int unsigned PosW   = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NumBytes = DataW / ByteW;

  // Outcome reported with each word
  typedef enum logic [1:0] {
    StGood   = 2'd0,
    StData   = 2'd1,
    StCheck  = 2'd2,
    StUncorr = 2'd3
  } status_e;

  // Decode table codes: 0..63 data bit (MSB numbering), 64..71 check bit 0..7
  localparam logic [7:0] CG = 8'hFE;  // syndrome clean
  localparam logic [7:0] CU = 8'hFF;  // uncorrectable
  localparam logic [7:0] K0 = 8'd64;
  localparam logic [7:0] K1 = 8'd65;
  localparam logic [7:0] K2 = 8'd66;
  localparam logic [7:0] K3 = 8'd67;
  localparam logic [7:0] K4 = 8'd68;
  localparam logic [7:0] K5 = 8'd69;
  localparam logic [7:0] K6 = 8'd70;
  localparam logic [7:0] K7 = 8'd71;

  // Check bit i is the parity of the data ANDed with row i
  localparam logic [DataW-1:0] MaskRows [CheckW] = '{
    64'h0000e8423c0f99ff,
    64'h00e8423c0f99ff00,
    64'he8423c0f99ff0000,
    64'h423c0f99ff0000e8,
    64'h3c0f99ff0000e842,
    64'h0f99ff0000e8423c,
    64'h99ff0000e8423c0f,
    64'hff0000e8423c0f99
  };

  localparam logic [7:0] SynTable [256] = '{
    CG, K7, K6, CU, K5, CU, CU, 8'd47, K4, CU, CU, 8'd37, CU, 8'd35, 8'd39, CU,
    K3, CU, CU, 8'd48, CU, 8'd30, 8'd29, CU, CU, 8'd57, 8'd27, CU, 8'd31, CU, CU, CU,
    K2, CU, CU, 8'd17, CU, 8'd18, 8'd40, CU, CU, 8'd58, 8'd22, CU, 8'd21, CU, CU, CU,
    CU, 8'd16, 8'd49, CU, 8'd19, CU, CU, CU, 8'd23, CU, CU, CU, CU, 8'd20, CU, CU,
    K1, CU, CU, 8'd51, CU, 8'd46, 8'd9, CU, CU, 8'd34, 8'd10, CU, 8'd32, CU, CU, 8'd36,
    CU, 8'd62, 8'd50, CU, 8'd14, CU, CU, CU, 8'd13, CU, CU, CU, CU, CU, CU, CU,
    CU, 8'd61, 8'd8, CU, 8'd41, CU, CU, CU, 8'd11, CU, CU, CU, CU, CU, CU, CU,
    8'd15, CU, CU, CU, CU, CU, CU, CU, CU, CU, 8'd12, CU, CU, CU, CU, CU,
    K0, CU, CU, 8'd55, CU, 8'd45, 8'd43, CU, CU, 8'd56, 8'd38, CU, 8'd1, CU, CU, CU,
    CU, 8'd25, 8'd26, CU, 8'd2, CU, CU, CU, 8'd24, CU, CU, CU, CU, CU, 8'd28, CU,
    CU, 8'd59, 8'd54, CU, 8'd42, CU, CU, 8'd44, 8'd6, CU, CU, CU, CU, CU, CU, CU,
    8'd5, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU,
    CU, 8'd63, 8'd53, CU, 8'd0, CU, CU, CU, 8'd33, CU, CU, CU, CU, CU, CU, CU,
    8'd3, CU, CU, 8'd52, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU,
    8'd7, CU, CU, CU, CU, CU, CU, CU, CU, 8'd60, CU, CU, CU, CU, CU, CU,
    CU, CU, CU, CU, 8'd4, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU, CU
  };

  // Word leaving the syndrome stages
  typedef struct packed {
    logic              valid;
    logic [DataW-1:0]  data;
    logic [CheckW-1:0] syndrome;
    logic              last;
  } syn_stage_t;

endpackage

// ===== src/sec_syn_calc.sv =====
// Syndrome stages of the SECDED (72,64) checker: byte-wise partial parities,
// then the folded check bits XORed with the stored byte. Depends on sec_pkg.
module sec_syn_calc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          valid_i,
  input  logic [sec_pkg::DataW-1:0]     data_i,
  input  logic [sec_pkg::CheckW-1:0]    check_i,
  input  logic                          last_i,
  output sec_pkg::syn_stage_t           syn_o
);

  logic                                          p1_valid_q;
  logic [sec_pkg::DataW-1:0]                     p1_data_q;
  logic [sec_pkg::CheckW-1:0]                    p1_check_q;
  logic                                          p1_last_q;
  logic [sec_pkg::CheckW-1:0][sec_pkg::NumBytes-1:0] part_d, part_q;

  logic                              p2_valid_q;
  logic [sec_pkg::DataW-1:0]         p2_data_q;
  logic [sec_pkg::CheckW-1:0]        syn_d, syn_q;
  logic                              p2_last_q;

  // Parity of each mask row over each data byte
  always_comb begin
    for (int i = 0; i < sec_pkg::CheckW; i++) begin
      for (int j = 0; j < sec_pkg::NumBytes; j++) begin
        part_d[i][j] = ^(data_i[j*sec_pkg::ByteW +: sec_pkg::ByteW]
                         & sec_pkg::MaskRows[i][j*sec_pkg::ByteW +: sec_pkg::ByteW]);
      end
    end
  end

  // Fold the partials and compare against the stored byte
  always_comb begin
    for (int i = 0; i < sec_pkg::CheckW; i++) begin
      syn_d[i] = (^part_q[i]) ^ p1_check_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else if (advance_i) begin
      p1_valid_q <= valid_i;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      p1_data_q  <= data_i;
      p1_check_q <= check_i;
      p1_last_q  <= last_i;
      part_q     <= part_d;
      p2_data_q  <= p1_data_q;
      p2_last_q  <= p1_last_q;
      syn_q      <= syn_d;
    end
  end

  assign syn_o.valid    = p2_valid_q;
  assign syn_o.data     = p2_data_q;
  assign syn_o.syndrome = syn_q;
  assign syn_o.last     = p2_last_q;

endmodule

// ===== src/secded_72_64_check_correct.sv =====
// Top level of the SECDED (72,64) check-and-correct pipeline.
// Depends on sec_pkg and sec_syn_calc.
//
// Takes one 72-bit word (64 data bits plus the stored check byte) a cycle and
// returns it checked: clean, a data bit corrected, a check bit in error, or
// uncorrectable. From input acceptance a word passes through two syndrome
// stages, the table lookup and the correction/output register before showing
// on the output. Throughput is one word per clock; the whole
// pipeline advances together and freezes only while the output register holds
// a word the consumer has not taken, so back-pressure reaches the input at
// once and nothing is dropped or repeated. Uncorrectable words still pass
// through with status 3; stopping the stream is left to the consumer.
module secded_72_64_check_correct (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [63:0] data_word, [71:64] check_byte
  input  logic        s_axis_tlast_i,   // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [63:0] data_out, [65:64] status,
                                        // [72:66] error_position, [79:73] zero
  output logic        m_axis_tlast_o    // last_out
);

  logic                advance;
  sec_pkg::syn_stage_t syn;

  // Lookup stage
  logic                      lk_valid_q;
  logic [sec_pkg::DataW-1:0] lk_data_q;
  logic [7:0]                lk_code_q;
  logic                      lk_last_q;

  // Output register
  logic                       out_valid_q;
  logic [sec_pkg::DataW-1:0]  out_data_d, out_data_q;
  sec_pkg::status_e           out_status_d, out_status_q;
  logic [sec_pkg::PosW-1:0]   out_pos_d, out_pos_q;
  logic                       out_last_q;

  // Advance everything unless the output word is stalled
  assign advance         = !(out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = advance;

  sec_syn_calc u_syn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (s_axis_tvalid_i),
    .data_i    (s_axis_tdata_i[63:0]),
    .check_i   (s_axis_tdata_i[71:64]),
    .last_i    (s_axis_tlast_i),
    .syn_o     (syn)
  );

  // Decode the table code: flip the named data bit (MSB numbering), or report
  always_comb begin
    out_data_d   = lk_data_q;
    out_status_d = sec_pkg::StCheck;
    out_pos_d    = lk_code_q[sec_pkg::PosW-1:0];
    if (lk_code_q == sec_pkg::CG) begin
      out_status_d = sec_pkg::StGood;
      out_pos_d    = '0;
    end else if (lk_code_q == sec_pkg::CU) begin
      out_status_d = sec_pkg::StUncorr;
      out_pos_d    = '0;
    end else if (lk_code_q[7:6] == 2'b00) begin
      out_status_d = sec_pkg::StData;
      out_data_d[~lk_code_q[5:0]] = ~lk_data_q[~lk_code_q[5:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      lk_valid_q  <= syn.valid;
      out_valid_q <= lk_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lk_data_q    <= syn.data;
      lk_code_q    <= sec_pkg::SynTable[syn.syndrome];
      lk_last_q    <= syn.last;
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_last_q   <= lk_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_pos_q, out_status_q, out_data_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== src/sec_checker.sv =====
// Port-level assertions for the SECDED (72,64) check-and-correct block,
// bound to the top level. Depends on sec_pkg.
module sec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [71:0] s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // Input is refused only while the output is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input refused without output stall");

  // With the consumer ready throughout, an accepted word appears carrying its tlast
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 4) && $past(in_acc, 4) && $past(m_axis_tready_i, 1)
      && $past(m_axis_tready_i, 2) && $past(m_axis_tready_i, 3)
      |-> m_axis_tvalid_o && (m_axis_tlast_o == $past(s_axis_tlast_i, 4)))
    else $error("word lost or tlast mismatch through pipeline");

  // Position is zero unless a bit was named; check-bit positions lie in 64..71
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[65:64] == sec_pkg::StGood && m_axis_tdata_o[72:66] == 7'd0)
    || (m_axis_tdata_o[65:64] == sec_pkg::StUncorr && m_axis_tdata_o[72:66] == 7'd0)
    || (m_axis_tdata_o[65:64] == sec_pkg::StData && !m_axis_tdata_o[72])
    || (m_axis_tdata_o[65:64] == sec_pkg::StCheck && m_axis_tdata_o[72:69] == 4'b1000)))
    else $error("error position inconsistent with status");

endmodule

bind secded_72_64_check_correct sec_checker u_sec_checker (.*);
